// ----- hw/rtl/hrp_pkg.sv -----
// Shared types, codes and helper functions of the HTTP request head parser.
`default_nettype none

package hrp_pkg;

    // Parser phase codes
    localparam logic [2:0] PH_METHOD  = 3'd0;
    localparam logic [2:0] PH_PATH    = 3'd1;
    localparam logic [2:0] PH_QUERY   = 3'd2;
    localparam logic [2:0] PH_VERSION = 3'd3;
    localparam logic [2:0] PH_HEADER  = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_ERROR   = 3'd6;

    // Result kinds
    localparam logic [2:0] K_PATH   = 3'd0;
    localparam logic [2:0] K_QUERY  = 3'd1;
    localparam logic [2:0] K_HNAME  = 3'd2;
    localparam logic [2:0] K_HVALUE = 3'd3;
    localparam logic [2:0] K_HEND   = 3'd4;
    localparam logic [2:0] K_ACCEPT = 3'd5;
    localparam logic [2:0] K_HDONE  = 3'd6;
    localparam logic [2:0] K_ERROR  = 3'd7;

    // Method codes
    localparam logic [2:0] M_GET    = 3'd0;
    localparam logic [2:0] M_POST   = 3'd1;
    localparam logic [2:0] M_HEAD   = 3'd2;
    localparam logic [2:0] M_PUT    = 3'd3;
    localparam logic [2:0] M_DELETE = 3'd4;

    // Characters
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_SP    = 8'h20;
    localparam logic [7:0] CHR_QMARK = 8'h3F;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_ONE   = 8'h31;

    // Longest method name, and version length
    localparam int unsigned METHOD_MAX_LEN = 6;
    localparam logic [3:0]  VER_LEN        = 4'd8;
    localparam logic [3:0]  VER_PREFIX_LEN = 4'd7;

    // Per-item parse state (method text and length live in the core)
    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] ver_count;
        logic       ver_prefix_ok;
        logic [7:0] ver_last;
        logic       colon_seen;
    } st_t;

    // One result item
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [2:0] method_code;
        logic       minor_version;
        logic       last;
    } out_item_t;

    // Outcome of feeding one byte or one line end
    typedef struct packed {
        st_t       st;
        logic      emit;
        out_item_t item;
        logic      append;
    } feed_t;

    // Method match outcome
    typedef struct packed {
        logic       ok;
        logic [2:0] code;
    } match_t;

    // Results of one processed item, toward the output stage
    typedef struct packed {
        logic [1:0] count;
        out_item_t  item0;
        out_item_t  item1;
    } step_res_t;

    // "HTTP/1." one byte at a time
    function automatic logic [7:0] hrp_ver_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2F;
            3'd5:    c = 8'h31;
            3'd6:    c = 8'h2E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Match the stored method text against the known methods
    function automatic match_t hrp_match(input logic [5:0][7:0] txt, input logic [2:0] len3,
                                         input logic len_small);
        match_t m;
        m.ok   = 1'b0;
        m.code = M_GET;
        if (len_small && len3 == 3'd3 && {txt[0], txt[1], txt[2]} == "GET") begin
            m.ok   = 1'b1;
            m.code = M_GET;
        end
        else if (len_small && len3 == 3'd4 && {txt[0], txt[1], txt[2], txt[3]} == "POST")
        begin
            m.ok   = 1'b1;
            m.code = M_POST;
        end
        else if (len_small && len3 == 3'd4 && {txt[0], txt[1], txt[2], txt[3]} == "HEAD")
        begin
            m.ok   = 1'b1;
            m.code = M_HEAD;
        end
        else if (len_small && len3 == 3'd3 && {txt[0], txt[1], txt[2]} == "PUT") begin
            m.ok   = 1'b1;
            m.code = M_PUT;
        end
        else if (len_small && len3 == 3'd6 &&
                 {txt[0], txt[1], txt[2], txt[3], txt[4], txt[5]} == "DELETE") begin
            m.ok   = 1'b1;
            m.code = M_DELETE;
        end
        return m;
    endfunction

    // Build a result item
    function automatic out_item_t hrp_item(input logic [2:0] kind, input logic [7:0] data);
        out_item_t it;
        it.kind          = kind;
        it.data          = data;
        it.method_code   = 3'd0;
        it.minor_version = 1'b0;
        it.last          = 1'b0;
        return it;
    endfunction

    // Ordinary byte in the current phase
    function automatic feed_t hrp_feed(input st_t s, input logic [7:0] b, input logic m_ok);
        feed_t f;
        f.st     = s;
        f.emit   = 1'b0;
        f.item   = hrp_item(K_PATH, 8'h00);
        f.append = 1'b0;
        case (s.phase)
            PH_METHOD:
            begin
                if (b == CHR_SP) begin
                    if (m_ok) begin
                        f.st.phase = PH_PATH;
                    end
                    else begin
                        f.st.phase = PH_ERROR;
                        f.emit     = 1'b1;
                        f.item     = hrp_item(K_ERROR, 8'h00);
                    end
                end
                else begin
                    f.append = 1'b1;
                end
            end
            PH_PATH:
            begin
                if (b == CHR_SP) begin
                    f.st.phase = PH_VERSION;
                end
                else if (b == CHR_QMARK) begin
                    f.st.phase = PH_QUERY;
                    f.emit     = 1'b1;
                    f.item     = hrp_item(K_QUERY, b);
                end
                else begin
                    f.emit = 1'b1;
                    f.item = hrp_item(K_PATH, b);
                end
            end
            PH_QUERY:
            begin
                if (b == CHR_SP) begin
                    f.st.phase = PH_VERSION;
                end
                else begin
                    f.emit = 1'b1;
                    f.item = hrp_item(K_QUERY, b);
                end
            end
            PH_VERSION:
            begin
                if (s.ver_count < VER_PREFIX_LEN) begin
                    if (b != hrp_ver_char(s.ver_count[2:0])) begin
                        f.st.ver_prefix_ok = 1'b0;
                    end
                end
                else if (s.ver_count == VER_PREFIX_LEN) begin
                    f.st.ver_last = b;
                end
                // count saturates one past the full length
                if (s.ver_count <= VER_LEN) begin
                    f.st.ver_count = s.ver_count + 4'd1;
                end
            end
            PH_HEADER:
            begin
                if (!s.colon_seen) begin
                    if (b == CHR_COLON) begin
                        f.st.colon_seen = 1'b1;
                    end
                    else begin
                        f.emit = 1'b1;
                        f.item = hrp_item(K_HNAME, b);
                    end
                end
                else begin
                    f.emit = 1'b1;
                    f.item = hrp_item(K_HVALUE, b);
                end
            end
            default:
            begin
            end
        endcase
        return f;
    endfunction

    // CR LF seen in the current phase
    function automatic feed_t hrp_line_end(input st_t s, input match_t m);
        feed_t f;
        f.st     = s;
        f.emit   = 1'b0;
        f.item   = hrp_item(K_PATH, 8'h00);
        f.append = 1'b0;
        case (s.phase)
            PH_VERSION:
            begin
                f.emit = 1'b1;
                if (s.ver_count == VER_LEN && s.ver_prefix_ok && m.ok &&
                    (s.ver_last == CHR_ZERO || s.ver_last == CHR_ONE)) begin
                    f.st.phase              = PH_HEADER;
                    f.st.colon_seen         = 1'b0;
                    f.item                  = hrp_item(K_ACCEPT, 8'h00);
                    f.item.method_code      = m.code;
                    f.item.minor_version    = (s.ver_last == CHR_ONE);
                end
                else begin
                    f.st.phase = PH_ERROR;
                    f.item     = hrp_item(K_ERROR, 8'h00);
                end
            end
            PH_HEADER:
            begin
                f.emit = 1'b1;
                if (s.colon_seen) begin
                    f.st.colon_seen = 1'b0;
                    f.item          = hrp_item(K_HEND, 8'h00);
                end
                else begin
                    f.st.phase = PH_DONE;
                    f.item     = hrp_item(K_HDONE, 8'h00);
                end
            end
            PH_METHOD, PH_PATH, PH_QUERY:
            begin
                f.emit     = 1'b1;
                f.st.phase = PH_ERROR;
                f.item     = hrp_item(K_ERROR, 8'h00);
            end
            default:
            begin
            end
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hrp_core.sv -----
// Parse state and per-byte step logic of the HTTP request head parser.
`default_nettype none

module hrp_core #(
    parameter int unsigned METHOD_BUF_LEN = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              proc,
    input  wire logic [7:0]        data_byte,
    output hrp_pkg::step_res_t     res
);

    localparam int unsigned LW = $clog2(METHOD_BUF_LEN + 2);

    hrp_pkg::st_t     st_reg, st_next;
    logic             cr_reg, cr_next;
    logic             cr1;
    logic [LW-1:0]    mlen_reg, mlen_next;
    logic [7:0]       text_reg [METHOD_BUF_LEN];

    logic [5:0][7:0]  text6;
    hrp_pkg::match_t  match0;
    hrp_pkg::feed_t   f1, f2;
    logic             f1_en, f2_en, le_en;
    logic [7:0]       f1_byte;
    logic [LW-1:0]    mlen1;
    logic             wr1, wr2;
    logic             e1, e2;
    hrp_pkg::out_item_t it1, it2;

    // Method match from the stored text
    always_comb
    begin
        for (int i = 0; i < 6; i++) begin
            text6[i] = text_reg[i];
        end
        match0 = hrp_pkg::hrp_match(text6, mlen_reg[2:0],
                                    mlen_reg <= LW'(hrp_pkg::METHOD_MAX_LEN));
    end

    // Select which actions this byte causes
    always_comb
    begin
        f1_en   = 1'b0;
        le_en   = 1'b0;
        f1_byte = data_byte;
        cr1     = cr_reg;
        if (proc) begin
            if (st_reg.phase == hrp_pkg::PH_DONE || st_reg.phase == hrp_pkg::PH_ERROR) begin
                cr1 = 1'b0;
            end
            else if (cr_reg) begin
                cr1 = 1'b0;
                if (data_byte == hrp_pkg::CHR_LF) begin
                    le_en = 1'b1;
                end
                else begin
                    // lone CR is an ordinary byte ahead of this one
                    f1_en   = 1'b1;
                    f1_byte = hrp_pkg::CHR_CR;
                end
            end
            else if (data_byte == hrp_pkg::CHR_CR) begin
                cr1 = 1'b1;
            end
            else begin
                f1_en = 1'b1;
            end
        end
    end

    // First action: a byte or a line end
    always_comb
    begin
        if (le_en) begin
            f1 = hrp_pkg::hrp_line_end(st_reg, match0);
        end
        else begin
            f1 = hrp_pkg::hrp_feed(st_reg, f1_byte, match0.ok);
        end
    end

    // Second action only after a lone CR; a CR in the method text never matches
    always_comb
    begin
        f2 = hrp_pkg::hrp_feed(f1.st, data_byte, match0.ok && !f1.append);
        f2_en   = 1'b0;
        cr_next = cr1;
        if (f1_en && cr_reg && f1.st.phase != hrp_pkg::PH_DONE &&
            f1.st.phase != hrp_pkg::PH_ERROR) begin
            if (data_byte == hrp_pkg::CHR_CR) begin
                cr_next = 1'b1;
            end
            else begin
                f2_en = 1'b1;
            end
        end
    end

    // Next state, method text writes
    always_comb
    begin
        st_next = st_reg;
        if (f2_en) begin
            st_next = f2.st;
        end
        else if (f1_en || le_en) begin
            st_next = f1.st;
        end
        wr1   = f1_en && f1.append;
        wr2   = f2_en && f2.append;
        mlen1 = mlen_reg;
        if (wr1 && mlen_reg <= LW'(METHOD_BUF_LEN)) begin
            mlen1 = mlen_reg + LW'(1);
        end
        mlen_next = mlen1;
        if (wr2 && mlen1 <= LW'(METHOD_BUF_LEN)) begin
            mlen_next = mlen1 + LW'(1);
        end
    end

    // Collect up to two results, last marks the final one
    always_comb
    begin
        e1  = (f1_en || le_en) && f1.emit;
        e2  = f2_en && f2.emit;
        it1 = f1.item;
        it2 = f2.item;
        res.count = {1'b0, e1} + {1'b0, e2};
        if (e1) begin
            res.item0      = it1;
            res.item0.last = !e2;
        end
        else begin
            res.item0      = it2;
            res.item0.last = 1'b1;
        end
        res.item1      = it2;
        res.item1.last = 1'b1;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg.phase         <= hrp_pkg::PH_METHOD;
            st_reg.ver_count     <= 4'd0;
            st_reg.ver_prefix_ok <= 1'b1;
            st_reg.ver_last      <= 8'h00;
            st_reg.colon_seen    <= 1'b0;
            cr_reg               <= 1'b0;
            mlen_reg             <= '0;
        end
        else begin
            st_reg   <= st_next;
            cr_reg   <= cr_next;
            mlen_reg <= mlen_next;
        end
    end

    // Method text, written at the current length
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < METHOD_BUF_LEN; i++) begin
            if (wr1 && mlen_reg == LW'(i)) begin
                text_reg[i] <= f1_byte;
            end
            else if (wr2 && mlen1 == LW'(i)) begin
                text_reg[i] <= data_byte;
            end
        end
    end

    // Error and done are sticky
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.phase == hrp_pkg::PH_ERROR) |=> (st_reg.phase == hrp_pkg::PH_ERROR))
        else $error("error phase left");
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.phase == hrp_pkg::PH_DONE) |=> (st_reg.phase == hrp_pkg::PH_DONE))
        else $error("done phase left");

endmodule

`default_nettype wire

// ----- hw/rtl/http_request_head_parser.sv -----
// Top level of the HTTP request head parser: stream ports, input and output registers.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: data_byte[7:0]
//  m_*     | out | m_tvalid/m_tready  | tdata: out_byte, method_code, minor_version;
//          |     |                    | tuser: kind; tlast: last
//
// One byte per cycle while the output register can take results: a byte is
// registered, then stepped through the parser and its results loaded into a
// two-entry output register. After a byte that causes two results the next
// byte waits in the input register until the single output port passes one on.
// Reset clears phase and handshake state at once; no clearing pass.
// A stalled output holds its results; the input register keeps one byte.
`default_nettype none

module http_request_head_parser #(
    parameter int unsigned METHOD_BUF_LEN = 6
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [10:8] method_code,
                                        // [11] minor_version, [15:12] zero
    output logic [2:0]       m_tuser,   // [2:0] kind
    output logic             m_tlast
);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    hrp_pkg::out_item_t  out0_reg, out1_reg;
    logic [1:0]          out_cnt_reg;
    logic                take, can_load, proc;
    hrp_pkg::step_res_t  res;

    // Handshake
    assign take     = m_tvalid && m_tready;
    assign can_load = (out_cnt_reg == 2'd0) || (out_cnt_reg == 2'd1 && m_tready);
    assign proc     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;

    hrp_core #(
        .METHOD_BUF_LEN (METHOD_BUF_LEN)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .proc      (proc),
        .data_byte (in_byte_reg),
        .res       (res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end
        else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Output register: item0 is shown, item1 waits behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_cnt_reg <= 2'd0;
        end
        else if (proc) begin
            out_cnt_reg <= res.count;
        end
        else if (take) begin
            out_cnt_reg <= out_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc) begin
            out0_reg <= res.item0;
            out1_reg <= res.item1;
        end
        else if (take) begin
            out0_reg <= out1_reg;
        end
    end

    // Output ports
    assign m_tvalid = (out_cnt_reg != 2'd0);
    assign m_tdata  = {4'b0000, out0_reg.minor_version, out0_reg.method_code, out0_reg.data};
    assign m_tuser  = out0_reg.kind;
    assign m_tlast  = out0_reg.last;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg != 2'd3)
        else $error("output count out of range");
    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_cnt_reg == 2'd2) |-> (!out0_reg.last && out1_reg.last))
        else $error("result pair marked wrong");
    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !can_load) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held input item lost");

endmodule

`default_nettype wire
